[design/lcsm_pkg.sv]
// Shared types and constants for the lexer character state machine.
// No dependencies; every design file imports this package.
package lcsm_pkg;

    // Width of the line, column and error count outputs.
    localparam int OUT_WIDTH = 16;
    // Default internal counter width.
    localparam int DEFAULT_COUNTER_WIDTH = 16;

    // Character codes that steer the lexer.
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NL      = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_HASH    = 8'd35;
    localparam logic [7:0] CHAR_TILDE   = 8'd126;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_NINE    = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    // Lexer modes.
    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_COMMENT = 2'd3
    } lex_mode_t;

    // Token kinds.
    typedef enum logic [1:0] {
        KIND_IDENT   = 2'd0,
        KIND_NUMBER  = 2'd1,
        KIND_COMMENT = 2'd2
    } token_kind_t;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_UNRECOGNIZED = 3'd1,
        ERR_BAD_START    = 3'd2,
        ERR_BAD_IDENT    = 3'd3,
        ERR_DIGIT_LETTER = 3'd4,
        ERR_BAD_NUMBER   = 3'd5
    } error_code_t;

    // Per-beat decode result passed from the decoder to the rest of the block.
    typedef struct packed {
        logic        append;
        logic        token_done;
        token_kind_t token_kind;
        error_code_t error_code;
        logic        newline;
    } lex_dec_t;

endpackage

[design/lcsm_decode.sv]
// Combinational lexer decode: byte classes, next mode and per-beat flags.
// Depends on lcsm_pkg.
module lcsm_decode (
    input  logic [7:0]         byte_in,
    input  logic               is_end,
    input  lcsm_pkg::lex_mode_t mode,
    output lcsm_pkg::lex_mode_t mode_next,
    output lcsm_pkg::lex_dec_t  dec
);
    import lcsm_pkg::*;

    logic is_valid;
    logic is_letter;
    logic is_digit;
    logic is_sep;
    logic is_nl;
    logic is_hash;

    // Byte classification; the end marker counts as a valid character.
    assign is_nl     = (byte_in == CHAR_NL);
    assign is_hash   = (byte_in == CHAR_HASH);
    assign is_sep    = (byte_in == CHAR_TAB) || is_nl || (byte_in == CHAR_SPACE);
    assign is_valid  = is_end || (byte_in == CHAR_TAB) || is_nl
                       || ((byte_in >= CHAR_SPACE) && (byte_in <= CHAR_TILDE));
    assign is_letter = ((byte_in >= CHAR_UPPER_A) && (byte_in <= CHAR_UPPER_Z))
                       || ((byte_in >= CHAR_LOWER_A) && (byte_in <= CHAR_LOWER_Z));
    assign is_digit  = (byte_in >= CHAR_ZERO) && (byte_in <= CHAR_NINE);

    // Next mode.
    always_comb begin
        mode_next = mode;
        if (!is_valid && (mode != MODE_COMMENT)) begin
            mode_next = mode;
        end else begin
            unique case (mode)
                MODE_START: begin
                    priority if (is_end)    mode_next = MODE_START;
                    else if (is_letter)     mode_next = MODE_IDENT;
                    else if (is_digit)      mode_next = MODE_NUMBER;
                    else if (is_hash)       mode_next = MODE_COMMENT;
                    else                    mode_next = MODE_START;
                end
                MODE_IDENT: begin
                    if (!is_end && (is_letter || is_digit)) mode_next = MODE_IDENT;
                    else                                     mode_next = MODE_START;
                end
                MODE_NUMBER: begin
                    if (!is_end && is_digit) mode_next = MODE_NUMBER;
                    else                     mode_next = MODE_START;
                end
                MODE_COMMENT: begin
                    if (is_end || is_nl) mode_next = MODE_START;
                    else                 mode_next = MODE_COMMENT;
                end
                default: mode_next = MODE_START;
            endcase
        end
    end

    // Per-beat flags: append, token end, kind, error and newline.
    always_comb begin
        dec = '{append: 1'b0, token_done: 1'b0, token_kind: KIND_IDENT,
                error_code: ERR_NONE, newline: 1'b0};
        if (!is_valid && (mode != MODE_COMMENT)) begin
            dec.error_code = ERR_UNRECOGNIZED;
        end else begin
            unique case (mode)
                MODE_START: begin
                    priority if (is_end) begin
                        dec.append = 1'b0;
                    end else if (is_letter || is_digit || is_hash) begin
                        dec.append = 1'b1;
                    end else if (is_sep) begin
                        dec.newline = is_nl;
                    end else begin
                        dec.error_code = ERR_BAD_START;
                    end
                end
                MODE_IDENT: begin
                    if (!is_end && (is_letter || is_digit)) begin
                        dec.append = 1'b1;
                    end else begin
                        dec.token_done = 1'b1;
                        dec.token_kind = KIND_IDENT;
                        priority if (is_end) begin
                            dec.newline = 1'b0;
                        end else if (is_sep) begin
                            dec.newline = is_nl;
                        end else begin
                            dec.error_code = ERR_BAD_IDENT;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (!is_end && is_digit) begin
                        dec.append = 1'b1;
                    end else begin
                        dec.token_done = 1'b1;
                        dec.token_kind = KIND_NUMBER;
                        priority if (is_end) begin
                            dec.newline = 1'b0;
                        end else if (is_letter) begin
                            // The letter opens the next token's buffer.
                            dec.error_code = ERR_DIGIT_LETTER;
                            dec.append     = 1'b1;
                        end else if (is_sep) begin
                            dec.newline = is_nl;
                        end else begin
                            dec.error_code = ERR_BAD_NUMBER;
                        end
                    end
                end
                MODE_COMMENT: begin
                    if (is_end || is_nl) begin
                        dec.token_done = 1'b1;
                        dec.token_kind = KIND_COMMENT;
                        dec.newline    = !is_end;
                    end else begin
                        dec.append = 1'b1;
                    end
                end
                default: dec.error_code = ERR_NONE;
            endcase
        end
    end

endmodule

[design/lcsm_counters.sv]
// Saturating line, column and error counters with clipped 16-bit views.
// Depends on lcsm_pkg.
module lcsm_counters #(
    parameter int COUNTER_WIDTH = lcsm_pkg::DEFAULT_COUNTER_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          newline,
    input  logic                          err_inc,
    output logic [lcsm_pkg::OUT_WIDTH-1:0] line_here,
    output logic [lcsm_pkg::OUT_WIDTH-1:0] column_here,
    output logic [lcsm_pkg::OUT_WIDTH-1:0] error_total
);
    import lcsm_pkg::*;

    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNTER_WIDTH-1:0] line_reg,   line_next;
    logic [COUNTER_WIDTH-1:0] column_reg, column_next;
    logic [COUNTER_WIDTH-1:0] error_reg,  error_next;

    // Next values; every counter sticks at its maximum.
    always_comb begin
        line_next   = line_reg;
        column_next = column_reg;
        error_next  = error_reg;
        if (err_inc && (error_reg != CNT_MAX)) begin
            error_next = error_reg + CNT_ONE;
        end
        if (newline) begin
            if (line_reg != CNT_MAX) begin
                line_next = line_reg + CNT_ONE;
            end
            column_next = CNT_ONE;
        end else if (column_reg != CNT_MAX) begin
            column_next = column_reg + CNT_ONE;
        end
    end

    // Counters advance once per processed beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg   <= CNT_ONE;
            column_reg <= CNT_ONE;
            error_reg  <= '0;
        end else if (step) begin
            line_reg   <= line_next;
            column_reg <= column_next;
            error_reg  <= error_next;
        end
    end

    // Clip or zero-extend the counters to the output width. The error total includes this beat.
    generate
        if (COUNTER_WIDTH > OUT_WIDTH) begin : g_clip
            assign line_here   = (|line_reg[COUNTER_WIDTH-1:OUT_WIDTH])
                                 ? '1 : line_reg[OUT_WIDTH-1:0];
            assign column_here = (|column_reg[COUNTER_WIDTH-1:OUT_WIDTH])
                                 ? '1 : column_reg[OUT_WIDTH-1:0];
            assign error_total = (|error_next[COUNTER_WIDTH-1:OUT_WIDTH])
                                 ? '1 : error_next[OUT_WIDTH-1:0];
        end else begin : g_extend
            assign line_here   = OUT_WIDTH'(line_reg);
            assign column_here = OUT_WIDTH'(column_reg);
            assign error_total = OUT_WIDTH'(error_next);
        end
    endgenerate

endmodule

[design/lexer_char_state_machine_unit.sv]
// Lexer character state machine: one source byte or end marker per beat in,
// one classified result beat out.
// Path: input register, then result register; back-pressure on m_ready holds the beat in the
// input register. Throughput: one beat per cycle while the result side accepts beats, set by the
// mode and counter update loop.
// Reset (synchronous, active low) returns the lexer to the start mode, line 1, column 1,
// zero errors, and empties both stages.
module lexer_char_state_machine_unit #(
    parameter int COUNTER_WIDTH = lcsm_pkg::DEFAULT_COUNTER_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_byte_in,
    input  logic                          s_is_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_byte_out,
    output logic                          m_append,
    output logic                          m_token_done,
    output logic [1:0]                    m_token_kind,
    output logic [2:0]                    m_error_code,
    output logic [lcsm_pkg::OUT_WIDTH-1:0] m_line_no,
    output logic [lcsm_pkg::OUT_WIDTH-1:0] m_column_no,
    output logic [lcsm_pkg::OUT_WIDTH-1:0] m_error_total
);
    import lcsm_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       advance;

    lex_mode_t mode_reg, mode_next;
    lex_dec_t  dec;

    logic [OUT_WIDTH-1:0] line_here;
    logic [OUT_WIDTH-1:0] column_here;
    logic [OUT_WIDTH-1:0] error_total;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_append_reg;
    logic                 out_done_reg;
    logic [1:0]           out_kind_reg;
    logic [2:0]           out_error_reg;
    logic [OUT_WIDTH-1:0] out_line_reg;
    logic [OUT_WIDTH-1:0] out_column_reg;
    logic [OUT_WIDTH-1:0] out_total_reg;

    // The held beat moves on when the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
            in_end_reg  <= s_is_end;
        end
    end

    // Decode of the held beat against the current mode.
    lcsm_decode u_decode (
        .byte_in   (in_byte_reg),
        .is_end    (in_end_reg),
        .mode      (mode_reg),
        .mode_next (mode_next),
        .dec       (dec)
    );

    lcsm_counters #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .newline     (dec.newline),
        .err_inc     (dec.error_code != ERR_NONE),
        .line_here   (line_here),
        .column_here (column_here),
        .error_total (error_total)
    );

    // Lexer mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_START;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg   <= in_end_reg ? 8'd0 : in_byte_reg;
            out_append_reg <= dec.append;
            out_done_reg   <= dec.token_done;
            out_kind_reg   <= dec.token_done ? dec.token_kind : KIND_IDENT;
            out_error_reg  <= dec.error_code;
            out_line_reg   <= line_here;
            out_column_reg <= column_here;
            out_total_reg  <= error_total;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_byte_out    = out_byte_reg;
    assign m_append      = out_append_reg;
    assign m_token_done  = out_done_reg;
    assign m_token_kind  = out_kind_reg;
    assign m_error_code  = out_error_reg;
    assign m_line_no     = out_line_reg;
    assign m_column_no   = out_column_reg;
    assign m_error_total = out_total_reg;

endmodule

[bench/tb_lexer_char_state_machine_unit.sv]
`timescale 1ns / 1ps
// Self-checking bench for lexer_char_state_machine_unit: a directed table and random token
// streams, each result beat checked against a hand-written result or an in-bench lexer model.
// Depends on lcsm_pkg and the lexer_char_state_machine_unit RTL only.
module tb_lexer_char_state_machine_unit;
    import lcsm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam logic [OUT_WIDTH-1:0] COUNT_TOP = {OUT_WIDTH{1'b1}};

    // One result beat as the lexer should produce it.
    typedef struct packed {
        logic [7:0]           byte_out;
        logic                 append;
        logic                 token_done;
        token_kind_t          token_kind;
        error_code_t          error_code;
        logic [OUT_WIDTH-1:0] line_no;
        logic [OUT_WIDTH-1:0] column_no;
        logic [OUT_WIDTH-1:0] error_total;
    } lex_beat_t;

    // One row of the directed table; rows marked known carry a hand-written result.
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       known;
        lex_beat_t  want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_byte_in = 8'd0;
    logic                 s_is_end = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [7:0]           m_byte_out;
    logic                 m_append;
    logic                 m_token_done;
    logic [1:0]           m_token_kind;
    logic [2:0]           m_error_code;
    logic [OUT_WIDTH-1:0] m_line_no;
    logic [OUT_WIDTH-1:0] m_column_no;
    logic [OUT_WIDTH-1:0] m_error_total;

    // Lexer state mirrored by the bench.
    lex_mode_t            scan_mode;
    logic [OUT_WIDTH-1:0] line_cnt;
    logic [OUT_WIDTH-1:0] col_cnt;
    logic [OUT_WIDTH-1:0] err_cnt;

    lex_beat_t   pending_beats[$];
    stim_row_t   dir_tab[26];
    int unsigned src_idle_pct = 17;
    int unsigned snk_idle_pct = 52;
    int unsigned beats_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;

    lexer_char_state_machine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .s_is_end      (s_is_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_out    (m_byte_out),
        .m_append      (m_append),
        .m_token_done  (m_token_done),
        .m_token_kind  (m_token_kind),
        .m_error_code  (m_error_code),
        .m_line_no     (m_line_no),
        .m_column_no   (m_column_no),
        .m_error_total (m_error_total)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [OUT_WIDTH-1:0] sat_inc(input logic [OUT_WIDTH-1:0] v);
        return (v == COUNT_TOP) ? v : v + 1'b1;
    endfunction

    // Classify one byte, advance the mirrored lexer state and return the expected beat.
    // The counters have the same width as the outputs, so no clipping is needed.
    function automatic lex_beat_t scan_byte(input logic [7:0] ch, input logic eoi);
        lex_beat_t r;
        logic      printable;
        logic      letter;
        logic      digit;
        logic      sep;
        logic      nl;
        lex_mode_t nxt;
        r = '0;
        nl = 1'b0;
        nxt = scan_mode;
        printable = eoi || ch == CHAR_TAB || ch == CHAR_NL ||
                    (ch >= CHAR_SPACE && ch <= CHAR_TILDE);
        letter = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
                 (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z);
        digit = ch >= CHAR_ZERO && ch <= CHAR_NINE;
        sep = ch == CHAR_TAB || ch == CHAR_NL || ch == CHAR_SPACE;
        r.byte_out = eoi ? 8'd0 : ch;
        r.line_no = line_cnt;
        r.column_no = col_cnt;

        if (!printable && scan_mode != MODE_COMMENT) begin
            // Unprintable bytes are rejected without touching the mode.
            r.error_code = ERR_UNRECOGNIZED;
        end else begin
            case (scan_mode)
                MODE_START: begin
                    if (!eoi) begin
                        if (letter) begin
                            r.append = 1'b1;
                            nxt = MODE_IDENT;
                        end else if (digit) begin
                            r.append = 1'b1;
                            nxt = MODE_NUMBER;
                        end else if (sep) begin
                            nl = (ch == CHAR_NL);
                        end else if (ch == CHAR_HASH) begin
                            r.append = 1'b1;
                            nxt = MODE_COMMENT;
                        end else begin
                            r.error_code = ERR_BAD_START;
                        end
                    end
                end
                MODE_IDENT: begin
                    if (!eoi && (letter || digit)) begin
                        r.append = 1'b1;
                    end else begin
                        r.token_done = 1'b1;
                        r.token_kind = KIND_IDENT;
                        nxt = MODE_START;
                        if (!eoi) begin
                            if (sep) nl = (ch == CHAR_NL);
                            else r.error_code = ERR_BAD_IDENT;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (!eoi && digit) begin
                        r.append = 1'b1;
                    end else begin
                        r.token_done = 1'b1;
                        r.token_kind = KIND_NUMBER;
                        nxt = MODE_START;
                        if (!eoi) begin
                            // A letter right after a digit starts the next buffer.
                            if (letter) begin
                                r.error_code = ERR_DIGIT_LETTER;
                                r.append = 1'b1;
                            end else if (sep) begin
                                nl = (ch == CHAR_NL);
                            end else begin
                                r.error_code = ERR_BAD_NUMBER;
                            end
                        end
                    end
                end
                default: begin
                    // Comments take every byte until a newline or the end marker.
                    if (eoi || ch == CHAR_NL) begin
                        r.token_done = 1'b1;
                        r.token_kind = KIND_COMMENT;
                        nxt = MODE_START;
                        nl = !eoi;
                    end else begin
                        r.append = 1'b1;
                    end
                end
            endcase
        end

        if (r.error_code != ERR_NONE) err_cnt = sat_inc(err_cnt);
        if (nl) begin
            line_cnt = sat_inc(line_cnt);
            col_cnt = OUT_WIDTH'(1);
        end else begin
            col_cnt = sat_inc(col_cnt);
        end
        scan_mode = nxt;
        r.error_total = err_cnt;
        return r;
    endfunction

    function automatic stim_row_t plain_row(input logic [7:0] ch, input logic eoi);
        stim_row_t r;
        r = '0;
        r.ch = ch;
        r.eoi = eoi;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [7:0] ch, input logic eoi,
                                            input logic app, input logic done,
                                            input token_kind_t kind, input error_code_t code,
                                            input int unsigned line, input int unsigned col,
                                            input int unsigned total);
        stim_row_t r;
        r = plain_row(ch, eoi);
        r.known = 1'b1;
        r.want.byte_out = eoi ? 8'd0 : ch;
        r.want.append = app;
        r.want.token_done = done;
        r.want.token_kind = kind;
        r.want.error_code = code;
        r.want.line_no = OUT_WIDTH'(line);
        r.want.column_no = OUT_WIDTH'(col);
        r.want.error_total = OUT_WIDTH'(total);
        return r;
    endfunction

    function automatic logic [7:0] rand_letter();
        return $urandom_range(1) ? 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z))
                                 : 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Present one input beat, with an occasional gap first, and record its expected result
    // once the beat is taken.
    task automatic send_beat(input stim_row_t rw);
        lex_beat_t predicted;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_byte_in <= rw.ch;
        s_is_end <= rw.eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = scan_byte(rw.ch, rw.eoi);
        pending_beats.insert(pending_beats.size(), rw.known ? rw.want : predicted);
        beats_sent++;
    endtask

    // Hold the input side idle until every expected result beat has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
    endtask

    // Send one random lexeme: mostly well-formed tokens, some separators, end markers and noise.
    task automatic send_token();
        int unsigned len;
        logic [7:0]  ch;
        case ($urandom_range(9))
            0, 1, 2: begin
                send_beat(plain_row(rand_letter(), 1'b0));
                len = $urandom_range(6);
                repeat (len) begin
                    ch = ($urandom_range(2) == 0) ? rand_digit() : rand_letter();
                    send_beat(plain_row(ch, 1'b0));
                end
            end
            3, 4: begin
                len = $urandom_range(1, 5);
                repeat (len) send_beat(plain_row(rand_digit(), 1'b0));
            end
            5: begin
                send_beat(plain_row(CHAR_HASH, 1'b0));
                len = $urandom_range(8);
                repeat (len) begin
                    if ($urandom_range(9) == 0) ch = 8'($urandom_range(255));
                    else ch = 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
                    if (ch == CHAR_NL) ch = CHAR_SPACE;
                    send_beat(plain_row(ch, 1'b0));
                end
                if ($urandom_range(3) == 0) send_beat(plain_row(8'($urandom_range(255)), 1'b1));
                else send_beat(plain_row(CHAR_NL, 1'b0));
            end
            6: begin
                case ($urandom_range(2))
                    0: ch = CHAR_TAB;
                    1: ch = CHAR_NL;
                    default: ch = CHAR_SPACE;
                endcase
                send_beat(plain_row(ch, 1'b0));
            end
            7: send_beat(plain_row(8'($urandom_range(255)), 1'b1));
            8: send_beat(plain_row(8'($urandom_range(255)), 1'b0));
            default: send_beat(plain_row(8'($urandom_range(33, 126)), 1'b0));
        endcase
    endtask

    // Result side: random back-pressure, then compare each beat with the oldest expectation.
    always @(posedge aclk) begin
        lex_beat_t want;
        m_ready <= aresetn && ($urandom_range(99) >= snk_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_beats.size() == 0) begin
                $error("result beat arrived with no expectation pending");
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("byte_out", want.byte_out, m_byte_out);
                check_field("append", want.append, m_append);
                check_field("token_done", want.token_done, m_token_done);
                check_field("token_kind", want.token_kind, m_token_kind);
                check_field("error_code", want.error_code, m_error_code);
                check_field("line_no", want.line_no, m_line_no);
                check_field("column_no", want.column_no, m_column_no);
                check_field("error_total", want.error_total, m_error_total);
            end
        end
    end

    // Watchdog: give up when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL lexer_char_state_machine_unit");
            $finish;
        end
    end

    initial begin
        scan_mode = MODE_START;
        line_cnt = OUT_WIDTH'(1);
        col_cnt = OUT_WIDTH'(1);
        err_cnt = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed walk through every mode, token kind and error code.
        dir_tab = '{
            known_row(CHAR_LOWER_A, 1'b0, 1'b1, 1'b0, KIND_IDENT, ERR_NONE, 1, 1, 0),
            plain_row(CHAR_UPPER_Z, 1'b0),
            plain_row(CHAR_NINE, 1'b0),
            plain_row(CHAR_SPACE, 1'b0),
            plain_row(CHAR_ZERO, 1'b0),
            known_row(CHAR_LOWER_Z, 1'b0, 1'b1, 1'b1, KIND_NUMBER, ERR_DIGIT_LETTER, 1, 6, 1),
            plain_row(CHAR_UPPER_A, 1'b0),
            known_row(CHAR_TILDE, 1'b0, 1'b0, 1'b1, KIND_IDENT, ERR_BAD_IDENT, 1, 8, 2),
            plain_row(CHAR_HASH, 1'b0),
            plain_row(8'hFF, 1'b0),
            plain_row(8'h00, 1'b0),
            plain_row(CHAR_NL, 1'b0),
            plain_row(8'h35, 1'b0),
            known_row(8'h21, 1'b0, 1'b0, 1'b1, KIND_NUMBER, ERR_BAD_NUMBER, 2, 2, 3),
            known_row(8'h21, 1'b0, 1'b0, 1'b0, KIND_IDENT, ERR_BAD_START, 2, 3, 4),
            plain_row(8'h7F, 1'b0),
            plain_row(8'hFF, 1'b0),
            plain_row(CHAR_TAB, 1'b0),
            plain_row(8'h31, 1'b0),
            known_row(8'hAB, 1'b1, 1'b0, 1'b1, KIND_NUMBER, ERR_NONE, 2, 8, 6),
            plain_row(CHAR_HASH, 1'b0),
            plain_row(8'hFF, 1'b1),
            plain_row(8'h00, 1'b1),
            plain_row(8'h71, 1'b0),
            plain_row(8'h80, 1'b0),
            plain_row(CHAR_NL, 1'b0)
        };
        foreach (dir_tab[i]) send_beat(dir_tab[i]);
        drain_results();

        // Random token streams under three idling patterns.
        while (beats_sent < 200) send_token();
        drain_results();
        src_idle_pct = 52;
        snk_idle_pct = 17;
        while (beats_sent < 380) send_token();
        drain_results();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        while (beats_sent < 550) send_token();
        drain_results();
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("PASS lexer_char_state_machine_unit");
        end else begin
            $display("FAIL lexer_char_state_machine_unit");
        end
        $finish;
    end

endmodule

[sim.f]
design/lcsm_pkg.sv
design/lcsm_decode.sv
design/lcsm_counters.sv
design/lexer_char_state_machine_unit.sv
bench/tb_lexer_char_state_machine_unit.sv
